### src/lcs_pkg.sv
`default_nettype none

package lcs_pkg;

    localparam int MAX_REQUEST_SECTORS = 64;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int DIV_W       = 32;
    localparam int DVS_W       = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_SECTORS_PER_TRACK     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADS_COUNT           = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_SECTOR_OFFSET   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_START_HEAD_OFFSET     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_START_CYLINDER_OFFSET = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_SECTOR      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_NUMBER          = 3'd6;

    localparam logic [7:0] BIOS_READ_FUNCTION = 8'h02;
    localparam logic [7:0] HEAD_MINUS_ONE     = 8'hff;

    typedef struct packed {
        logic [31:0] block_address;
        logic [6:0]  sector_count;
        logic [31:0] buffer_address;
    } in_item_t;

    typedef struct packed {
        logic [15:0] cylinder;
        logic [7:0]  head_number;
        logic [7:0]  sector_number;
        logic [6:0]  chunk_sectors;
        logic [31:0] chunk_address;
        logic [15:0] bios_ax;
        logic [15:0] bios_cx;
        logic [15:0] bios_dx;
        logic [15:0] bios_es;
        logic [3:0]  bios_bx;
        logic        last_chunk;
    } out_item_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_result_t;

endpackage

`default_nettype wire

### src/lcs_divider.sv
`default_nettype none

module lcs_divider
    import lcs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output div_result_t           result
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign result.done      = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

`default_nettype wire

### src/lba_to_chs_read_splitter.sv
// lba to chs read splitter
// input channel (in_valid/in_ready/in_data) takes one read request: block
// address, sector count and buffer address. output channel (out_valid/
// out_ready/out_data) gives one item per track touched, with cylinder, head,
// sector, chunk size, destination address and packed bios register words.
// configuration is a plain write port (cfg_write/cfg_index/cfg_data), to be
// written only while the block is idle; the block itself does not enforce this.
// a request runs two serial divisions in one shared divider (by sectors per
// track, then by heads), forms the start position, then builds each chunk
// in ST_CHUNK and offers it in ST_SEND before building the next one.
// in_ready is high only while no request is in progress.
// a stalled receiver holds the current item on out_data with out_valid high;
// the sequencer waits in place until it is taken.
// reset returns the sequencer to idle, drops out_valid and loads the
// default geometry: 63 sectors, 16 heads, sector offset 1, 512-byte sectors,
// drive 0x80.
`default_nettype none

module lba_to_chs_read_splitter
    import lcs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_item_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_item_t                   out_data,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV1  = 3'd1;
    localparam logic [2:0] ST_DIV2  = 3'd2;
    localparam logic [2:0] ST_CHUNK = 3'd3;
    localparam logic [2:0] ST_SEND  = 3'd4;

    logic [5:0]  spt_reg;
    logic [8:0]  heads_reg;
    logic [7:0]  sso_reg;
    logic [7:0]  sho_reg;
    logic [15:0] sco_reg;
    logic [12:0] bps_reg;
    logic [7:0]  drive_reg;

    logic [2:0]  state_reg, state_next;
    logic [6:0]  rem_reg, rem_next;
    logic [31:0] addr_reg, addr_next;
    logic [5:0]  idx_reg, idx_next;
    logic [7:0]  head_reg, head_next;
    logic [7:0]  sec_reg, sec_next;
    logic [15:0] cyl_reg, cyl_next;
    out_item_t   out_reg, out_next;

    logic [5:0]  spt_eff;
    logic [8:0]  heads_eff;
    logic        in_accept;
    logic        div_start;
    logic [31:0] div_dividend;
    logic [8:0]  div_divisor;
    div_result_t div_res;

    logic [6:0]  req_count;
    logic [5:0]  left;
    logic [6:0]  cnt;
    logic [6:0]  rem_after;
    logic [8:0]  head_inc;
    logic [7:0]  head_start;
    logic [15:0] cyl_start;
    logic [19:0] advance;

    assign spt_eff   = (spt_reg == '0) ? 6'd1 : spt_reg;
    assign heads_eff = (heads_reg == '0) ? 9'd1 : heads_reg;

    assign in_ready  = state_reg == ST_IDLE;
    assign in_accept = in_valid && in_ready;
    assign out_valid = state_reg == ST_SEND;
    assign out_data  = out_reg;

    assign req_count = (in_data.sector_count > 7'(MAX_REQUEST_SECTORS))
                     ? 7'(MAX_REQUEST_SECTORS) : in_data.sector_count;

    // shared divider: first by sectors per track, then by heads
    assign div_start    = in_accept || (state_reg == ST_DIV1 && div_res.done);
    assign div_dividend = (state_reg == ST_IDLE) ? in_data.block_address : div_res.quotient;
    assign div_divisor  = (state_reg == ST_IDLE) ? {3'b0, spt_eff} : heads_eff;

    lcs_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .result   (div_res)
    );

    assign head_start = div_res.remainder[7:0] + sho_reg;
    assign cyl_start  = (div_res.quotient[15:0] + sco_reg)
                      - ((head_start == HEAD_MINUS_ONE) ? 16'd1 : 16'd0);

    assign left      = spt_eff - idx_reg;
    assign cnt       = (rem_reg < {1'b0, left}) ? rem_reg : {1'b0, left};
    assign rem_after = rem_reg - cnt;
    assign head_inc  = {1'b0, head_reg} + 9'd1;
    assign advance   = out_reg.chunk_sectors * bps_reg;

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        addr_next  = addr_reg;
        idx_next   = idx_reg;
        head_next  = head_reg;
        sec_next   = sec_reg;
        cyl_next   = cyl_reg;
        out_next   = out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    rem_next   = req_count;
                    addr_next  = in_data.buffer_address;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (div_res.done)
                begin
                    idx_next   = div_res.remainder[5:0];
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (div_res.done)
                begin
                    head_next  = head_start;
                    cyl_next   = cyl_start;
                    sec_next   = {2'b0, idx_reg} + sso_reg;
                    state_next = (rem_reg == '0) ? ST_IDLE : ST_CHUNK;
                end
            end
            ST_CHUNK:
            begin
                rem_next               = rem_after;
                out_next.cylinder      = cyl_reg;
                out_next.head_number   = head_reg;
                out_next.sector_number = sec_reg;
                out_next.chunk_sectors = cnt;
                out_next.chunk_address = addr_reg;
                out_next.bios_ax       = {BIOS_READ_FUNCTION, 1'b0, cnt};
                out_next.bios_cx       = {cyl_reg[7:0], cyl_reg[9:8], sec_reg[5:0]};
                out_next.bios_dx       = {head_reg, drive_reg};
                out_next.bios_es       = addr_reg[19:4];
                out_next.bios_bx       = addr_reg[3:0];
                out_next.last_chunk    = rem_after == '0;
                state_next             = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_ready)
                begin
                    idx_next  = '0;
                    sec_next  = sso_reg;
                    addr_next = addr_reg + {12'b0, advance};
                    if (head_inc > heads_eff - 9'd1)
                    begin
                        head_next = sho_reg;
                        cyl_next  = cyl_reg + 16'd1;
                    end
                    else
                    begin
                        head_next = head_inc[7:0];
                    end
                    state_next = out_reg.last_chunk ? ST_IDLE : ST_CHUNK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            spt_reg   <= 6'd63;
            heads_reg <= 9'd16;
            sso_reg   <= 8'd1;
            sho_reg   <= 8'd0;
            sco_reg   <= 16'd0;
            bps_reg   <= 13'd512;
            drive_reg <= 8'd128;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_SECTORS_PER_TRACK:     spt_reg   <= cfg_data[5:0];
                    REG_HEADS_COUNT:           heads_reg <= cfg_data[8:0];
                    REG_START_SECTOR_OFFSET:   sso_reg   <= cfg_data[7:0];
                    REG_START_HEAD_OFFSET:     sho_reg   <= cfg_data[7:0];
                    REG_START_CYLINDER_OFFSET: sco_reg   <= cfg_data[15:0];
                    REG_BYTES_PER_SECTOR:      bps_reg   <= cfg_data[12:0];
                    REG_DRIVE_NUMBER:          drive_reg <= cfg_data[7:0];
                    default:                   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        addr_reg <= addr_next;
        idx_reg  <= idx_next;
        head_reg <= head_next;
        sec_reg  <= sec_next;
        cyl_reg  <= cyl_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

### test/tb.sv
`default_nettype none

module tb;
    import lcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES     = 80;
    localparam int HOLD_CYCLES      = 400;
    localparam int RANDOM_PER_PHASE = 17;
    localparam int MAX_REPORTS      = 60;
    localparam int LIMIT_CYCLES     = 600000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_data;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // geometry as the block holds it
    logic [5:0]  geo_spt      = 6'd63;
    logic [8:0]  geo_heads    = 9'd16;
    logic [7:0]  off_sector   = 8'd1;
    logic [7:0]  off_head     = 8'd0;
    logic [15:0] off_cyl      = 16'd0;
    logic [12:0] sector_bytes = 13'd512;
    logic [7:0]  drive_id     = 8'h80;

    in_item_t  request_queue[$];
    out_item_t expected_chunks[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked    = 0;
    int hold_given    = 0;
    int hold_left     = 0;

    int requests_taken = 0;
    int chunks_seen    = 0;
    int geometries     = 1;
    int mismatches     = 0;

    lba_to_chs_read_splitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic split_into_chunks(input in_item_t req);
        logic [31:0] spt;
        logic [31:0] nh;
        logic [31:0] q1;
        logic [31:0] idx;
        logic [31:0] q2;
        logic [31:0] remaining;
        logic [31:0] left;
        logic [31:0] cnt;
        logic [31:0] head;
        logic [31:0] hnext;
        logic [31:0] cyl;
        logic [31:0] sec;
        logic [31:0] addr;
        out_item_t   c;
        spt = (geo_spt == 0) ? 32'd1 : 32'(geo_spt);
        nh = (geo_heads == 0) ? 32'd1 : 32'(geo_heads);
        remaining = 32'(req.sector_count);
        if (remaining > MAX_REQUEST_SECTORS)
            remaining = MAX_REQUEST_SECTORS;
        addr = req.buffer_address;
        q1 = req.block_address / spt;
        idx = req.block_address % spt;
        q2 = q1 / nh;
        head = ((q1 % nh) + 32'(off_head)) & 32'hff;
        cyl = (q2 + 32'(off_cyl)) & 32'hffff;
        if (head == 32'(HEAD_MINUS_ONE))
            cyl = (cyl - 32'd1) & 32'hffff;
        sec = (idx + 32'(off_sector)) & 32'hff;
        while (remaining != 0)
        begin
            left = spt - idx;
            cnt = (remaining < left) ? remaining : left;
            remaining = remaining - cnt;
            c.cylinder      = cyl[15:0];
            c.head_number   = head[7:0];
            c.sector_number = sec[7:0];
            c.chunk_sectors = cnt[6:0];
            c.chunk_address = addr;
            c.bios_ax       = {BIOS_READ_FUNCTION, cnt[7:0]};
            c.bios_cx       = {cyl[7:0], cyl[9:8], sec[5:0]};
            c.bios_dx       = {head[7:0], drive_id};
            c.bios_es       = addr[19:4];
            c.bios_bx       = addr[3:0];
            c.last_chunk    = (remaining == 0);
            expected_chunks.push_back(c);
            idx = 0;
            sec = 32'(off_sector);
            hnext = head + 32'd1;
            if (hnext > nh - 32'd1)
            begin
                head = 32'(off_head);
                cyl = (cyl + 32'd1) & 32'hffff;
            end
            else
                head = hnext & 32'hff;
            addr = addr + cnt * 32'(sector_bytes);
        end
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected 0x%0h got 0x%0h", $time, field, want, got);
        end
    endtask

    task automatic check_chunk(input out_item_t want, input out_item_t got);
        compare_field("cylinder", 32'(want.cylinder), 32'(got.cylinder));
        compare_field("head_number", 32'(want.head_number), 32'(got.head_number));
        compare_field("sector_number", 32'(want.sector_number), 32'(got.sector_number));
        compare_field("chunk_sectors", 32'(want.chunk_sectors), 32'(got.chunk_sectors));
        compare_field("chunk_address", want.chunk_address, got.chunk_address);
        compare_field("bios_ax", 32'(want.bios_ax), 32'(got.bios_ax));
        compare_field("bios_cx", 32'(want.bios_cx), 32'(got.bios_cx));
        compare_field("bios_dx", 32'(want.bios_dx), 32'(got.bios_dx));
        compare_field("bios_es", 32'(want.bios_es), 32'(got.bios_es));
        compare_field("bios_bx", 32'(want.bios_bx), 32'(got.bios_bx));
        compare_field("last_chunk", 32'(want.last_chunk), 32'(got.last_chunk));
    endtask

    always @(posedge clk)
    begin : request_driver
        logic     next_valid;
        in_item_t next_data;
        next_valid = in_valid;
        next_data  = in_data;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                split_into_chunks(in_data);
                requests_taken++;
                next_valid = 1'b0;
            end
            if (!next_valid && request_queue.size() != 0
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_valid = 1'b1;
                next_data  = request_queue.pop_front();
            end
        end
        in_valid <= next_valid;
        in_data  <= next_data;
    end

    always @(posedge clk)
    begin : chunk_monitor
        logic      next_ready;
        out_item_t want;
        next_ready = out_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                chunks_seen++;
                if (expected_chunks.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: chunk expected none got 0x%0h", $time, out_data);
                end
                else
                begin
                    want = expected_chunks.pop_front();
                    check_chunk(want, out_data);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (hold_given != hold_asked)
            begin
                hold_given++;
                hold_left  = HOLD_CYCLES;
                next_ready = 1'b0;
            end
            else
                next_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
        out_ready <= next_ready;
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_SECTORS_PER_TRACK:     geo_spt      = value[5:0];
            REG_HEADS_COUNT:           geo_heads    = value[8:0];
            REG_START_SECTOR_OFFSET:   off_sector   = value[7:0];
            REG_START_HEAD_OFFSET:     off_head     = value[7:0];
            REG_START_CYLINDER_OFFSET: off_cyl      = value[15:0];
            REG_BYTES_PER_SECTOR:      sector_bytes = value[12:0];
            REG_DRIVE_NUMBER:          drive_id     = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int spt, input int heads, input int sso,
                                input int sho, input int cyo, input int bps,
                                input int drive);
        write_reg(REG_SECTORS_PER_TRACK, 16'(spt));
        write_reg(REG_HEADS_COUNT, 16'(heads));
        write_reg(REG_START_SECTOR_OFFSET, 16'(sso));
        write_reg(REG_START_HEAD_OFFSET, 16'(sho));
        write_reg(REG_START_CYLINDER_OFFSET, 16'(cyo));
        write_reg(REG_BYTES_PER_SECTOR, 16'(bps));
        write_reg(REG_DRIVE_NUMBER, 16'(drive));
        geometries++;
    endtask

    task automatic add_request(input logic [31:0] lba, input logic [6:0] count,
                               input logic [31:0] buffer);
        in_item_t r;
        r.block_address  = lba;
        r.sector_count   = count;
        r.buffer_address = buffer;
        request_queue.push_back(r);
    endtask

    task automatic finish_phase();
        while (request_queue.size() != 0 || in_valid || expected_chunks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int send_pct, input int recv_pct, input bit hold);
        logic [31:0] spt_eff;
        logic [31:0] lba;
        logic [6:0]  count;
        logic [31:0] buffer;
        int          pick;
        set_geometry($urandom_range(0, 63),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                 : $urandom_range(1, 16),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 1,
                     ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 3),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 3),
                     $urandom_range(0, 8191),
                     $urandom_range(0, 255));
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        spt_eff = (geo_spt == 0) ? 32'd1 : 32'(geo_spt);
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
        begin
            case ($urandom_range(0, 3))
                0:       lba = $urandom;
                1:       lba = $urandom_range(0, 20000);
                2:       lba = $urandom_range(0, 300) * spt_eff + spt_eff - 32'd1;
                default: lba = $urandom_range(0, 2000000);
            endcase
            pick = $urandom_range(0, 19);
            if (pick == 0)
                count = 7'd0;
            else if (pick <= 2)
                count = 7'($urandom_range(65, 127));
            else if (pick <= 4)
                count = 7'd64;
            else
                count = 7'($urandom_range(1, 64));
            if ($urandom_range(0, 3) == 0)
                buffer = 32'hffffffff - $urandom_range(0, 65535);
            else
                buffer = $urandom;
            add_request(lba, count, buffer);
        end
        if (hold)
            hold_asked++;
        finish_phase();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: track and cylinder crossings, oversized and empty counts
        send_idle_pct = 32;
        recv_idle_pct = 46;
        add_request(32'd0, 7'd1, 32'h0);
        add_request(32'd0, 7'd64, 32'h1000);
        add_request(32'd62, 7'd2, 32'h0000_7c00);
        add_request(32'd1007, 7'd3, 32'h0001_0008);
        add_request(32'hffffffff, 7'd64, 32'hffffffff);
        add_request(32'd5, 7'd0, 32'h10);
        add_request(32'd100, 7'd127, 32'hfffff000);
        add_request(32'd1031184, 7'd5, 32'h0009_0000);
        add_request(32'd1032192, 7'd1, 32'h1234_5678);
        add_request(32'd1234567, 7'd65, 32'h0);
        finish_phase();

        // zero geometry with head offset of minus one
        set_geometry(0, 0, 0, 255, 0, 1, 0);
        add_request(32'd0, 7'd64, 32'hfffffff0);
        add_request(32'hffffffff, 7'd3, 32'h0);
        add_request(32'd12345, 7'd0, 32'h1);
        add_request(32'd70000, 7'd2, 32'h8000_000f);
        finish_phase();

        // large values in every register
        set_geometry(63, 256, 255, 255, 65535, 4096, 255);
        add_request(32'd0, 7'd64, 32'h0);
        add_request(32'd62, 7'd2, 32'hffffff00);
        add_request(32'd16065, 7'd64, 32'h000f_fff7);
        add_request(32'hffffffff, 7'd65, 32'h7);
        add_request(32'd16127, 7'd1, 32'h5555_aaaa);
        finish_phase();

        set_geometry(1, 1, 0, 0, 0, 1, 0);
        add_request(32'd7, 7'd64, 32'h0);
        add_request(32'h8000_0000, 7'd2, 32'hfffffffe);
        finish_phase();

        random_phase(32, 46, 1'b1);
        random_phase(32, 46, 1'b0);
        random_phase(46, 32, 1'b0);
        random_phase(46, 32, 1'b1);
        random_phase(0, 0, 1'b0);
        random_phase(0, 0, 1'b0);

        $display("%0d requests over %0d geometry settings, %0d chunks checked",
                 requests_taken, geometries, chunks_seen);
        $display("covered zero geometry, saturated counts, head wrap and address wrap");
        if (mismatches == 0)
            $display("lba_to_chs_read_splitter: match");
        else
            $display("lba_to_chs_read_splitter: mismatch");
        $finish;
    end

    initial
    begin
        #(LIMIT_CYCLES * 12);
        $display("timeout with %0d chunks outstanding", expected_chunks.size());
        $display("lba_to_chs_read_splitter: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
